// ===== rtl/bcc_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, codes and reset constants of the button click classifier.
package bcc_pkg;

  localparam int unsigned SCORE_W   = 10;
  localparam int unsigned REL_W     = 8;
  localparam int unsigned CLICK_W   = 8;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DAT_W = 10;

  localparam logic [SCORE_W-1:0] HOLD_MAX    = '1;
  localparam logic [REL_W-1:0]   REL_MAX     = '1;
  localparam logic [CLICK_W-1:0] CLICK_MAX   = '1;
  localparam logic [CLICK_W-1:0] DOUBLE_NEED = CLICK_W'(2);

  localparam logic [SCORE_W-1:0] SHORT_MIN_RST      = SCORE_W'(5);
  localparam logic [SCORE_W-1:0] SHORT_MAX_RST      = SCORE_W'(50);
  localparam logic [SCORE_W-1:0] LONG_MIN_RST       = SCORE_W'(100);
  localparam logic [SCORE_W-1:0] LONG_MAX_RST       = SCORE_W'(200);
  localparam logic [SCORE_W-1:0] EXTRA_LONG_MIN_RST = SCORE_W'(300);
  localparam logic [REL_W-1:0]   RELEASE_TICKS_RST  = REL_W'(10);

  typedef enum logic [1:0] {
    CLS_RELEASED = 2'd0,
    CLS_SHORT    = 2'd1,
    CLS_LONG     = 2'd2,
    CLS_EXTRA    = 2'd3
  } class_t;

  typedef enum logic [2:0] {
    EV_NONE   = 3'd0,
    EV_SINGLE = 3'd1,
    EV_DOUBLE = 3'd2,
    EV_LONG   = 3'd3,
    EV_EXTRA  = 3'd4
  } event_t;

  typedef enum logic {
    ACT_SCAN   = 1'b0,
    ACT_WINDOW = 1'b1
  } action_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SHORT_MIN      = 3'd0,
    REG_SHORT_MAX      = 3'd1,
    REG_LONG_MIN       = 3'd2,
    REG_LONG_MAX       = 3'd3,
    REG_EXTRA_LONG_MIN = 3'd4,
    REG_RELEASE_TICKS  = 3'd5
  } cfg_idx_t;

  typedef struct packed {
    logic [SCORE_W-1:0] short_min;
    logic [SCORE_W-1:0] short_max;
    logic [SCORE_W-1:0] long_min;
    logic [SCORE_W-1:0] long_max;
    logic [SCORE_W-1:0] extra_long_min;
    logic [REL_W-1:0]   release_ticks;
  } cfg_t;

endpackage

// ===== rtl/bcc_ifs.sv =====
`timescale 1ns / 1ps
// Valid/ready channel interfaces: scan requests, results and register writes.
interface bcc_in_if;
  logic valid;
  logic ready;
  logic action;
  logic pin_level;

  modport source (output valid, output action, output pin_level, input ready);
  modport sink   (input valid, input action, input pin_level, output ready);
endinterface

interface bcc_out_if
  import bcc_pkg::*;
  ;
  logic       valid;
  logic       ready;
  logic [2:0] event_res;
  logic [1:0] press_class;

  modport source (output valid, output event_res, output press_class, input ready);
  modport sink   (input valid, input event_res, input press_class, output ready);
endinterface

interface bcc_cfg_if
  import bcc_pkg::*;
  ;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [CFG_DAT_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== rtl/bcc_tracker.sv =====
`timescale 1ns / 1ps
// Press tracking state and the per-request classification update.
module bcc_tracker
  import bcc_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    en,
  input  action_t action,
  input  logic    pin_level,
  input  cfg_t    cfg,
  output event_t  event_res,
  output class_t  press_class
);

  logic [SCORE_W-1:0] hold_r, hold_nxt;
  logic [REL_W-1:0]   rel_r, rel_nxt;
  logic [CLICK_W-1:0] click_r, click_nxt;
  class_t             class_r, class_nxt;
  logic [SCORE_W-1:0] hold_inc;

  assign hold_inc = (hold_r != HOLD_MAX) ? hold_r + SCORE_W'(1) : hold_r;

  always_comb begin
    hold_nxt  = hold_r;
    rel_nxt   = rel_r;
    click_nxt = click_r;
    class_nxt = class_r;
    event_res = EV_NONE;
    if (en) begin
      if (action == ACT_WINDOW) begin
        if (click_r >= DOUBLE_NEED) begin
          event_res = EV_DOUBLE;
        end
        click_nxt = '0;
      end else if (!pin_level) begin
        // later band wins when bands overlap
        hold_nxt = hold_inc;
        if (hold_inc >= cfg.short_min && hold_inc <= cfg.short_max) begin
          class_nxt = CLS_SHORT;
        end
        if (hold_inc >= cfg.long_min && hold_inc <= cfg.long_max) begin
          class_nxt = CLS_LONG;
        end
        if (hold_inc >= cfg.extra_long_min) begin
          class_nxt = CLS_EXTRA;
          event_res = EV_EXTRA;
        end
      end else begin
        case (class_r)
          CLS_SHORT, CLS_LONG: begin
            if (rel_r >= cfg.release_ticks) begin
              class_nxt = CLS_RELEASED;
              hold_nxt  = '0;
              rel_nxt   = '0;
              if (class_r == CLS_SHORT) begin
                event_res = EV_SINGLE;
                if (click_r != CLICK_MAX) begin
                  click_nxt = click_r + CLICK_W'(1);
                end
              end else begin
                event_res = EV_LONG;
              end
            end else if (rel_r != REL_MAX) begin
              rel_nxt = rel_r + REL_W'(1);
            end
          end
          CLS_EXTRA: begin
            class_nxt = CLS_RELEASED;
            hold_nxt  = '0;
            rel_nxt   = '0;
          end
          default: begin
          end
        endcase
      end
    end
  end

  assign press_class = class_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_r  <= '0;
      rel_r   <= '0;
      click_r <= '0;
      class_r <= CLS_RELEASED;
    end else begin
      hold_r  <= hold_nxt;
      rel_r   <= rel_nxt;
      click_r <= click_nxt;
      class_r <= class_nxt;
    end
  end

endmodule

// ===== rtl/button_click_classifier_core.sv =====
`timescale 1ns / 1ps
// Top level of the button click classifier.
//
// Channels:
//   in_if  - one request per scan tick (action 0, with the active-low pin
//            level) or per double-click window check (action 1).
//   out_if - exactly one result per request: event_res and press_class.
//   cfg_if - register writes (index 0..5: short_min, short_max, long_min,
//            long_max, extra_long_min, release_ticks); always ready. Write
//            only while no request is in flight.
// Path: an accepted request is held in the input register, then classified
//   and placed in the result register when it advances; out_if.valid rises
//   once the result is there.
// Throughput: one request per cycle while the receiver keeps ready high; the
//   limit is the combinational score update and band compare in the tracker.
// Stall: when the receiver holds ready low, the result register holds and
//   the input register still takes one more request; after that in_if.ready
//   drops until the result is taken.
// Reset (rst_n low, synchronous): scores, click count and class clear, the
//   registers return to their default bands, both pipeline stages empty.
module button_click_classifier_core
  import bcc_pkg::*;
(
  input logic          clk,
  input logic          rst_n,
  bcc_in_if.sink       in_if,
  bcc_out_if.source    out_if,
  bcc_cfg_if.sink      cfg_if
);

  // Input register
  logic    s1_valid_r;
  action_t s1_action_r;
  logic    s1_pin_r;

  // Result register
  logic    out_valid_r;
  event_t  out_event_r;
  class_t  out_class_r;

  cfg_t    cfg_r;
  logic    advance;
  event_t  trk_event;
  class_t  trk_class;

  // Move the held request into the result stage when that stage frees up.
  assign advance     = s1_valid_r && (!out_valid_r || out_if.ready);
  assign in_if.ready = !s1_valid_r || advance;
  assign cfg_if.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_if.ready) begin
      s1_valid_r <= in_if.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_if.ready && in_if.valid) begin
      s1_action_r <= action_t'(in_if.action);
      s1_pin_r    <= in_if.pin_level;
    end
  end

  // Register file; writes beyond the list are dropped.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.short_min      <= SHORT_MIN_RST;
      cfg_r.short_max      <= SHORT_MAX_RST;
      cfg_r.long_min       <= LONG_MIN_RST;
      cfg_r.long_max       <= LONG_MAX_RST;
      cfg_r.extra_long_min <= EXTRA_LONG_MIN_RST;
      cfg_r.release_ticks  <= RELEASE_TICKS_RST;
    end else if (cfg_if.valid) begin
      unique case (cfg_idx_t'(cfg_if.index))
        REG_SHORT_MIN:      cfg_r.short_min      <= cfg_if.data;
        REG_SHORT_MAX:      cfg_r.short_max      <= cfg_if.data;
        REG_LONG_MIN:       cfg_r.long_min       <= cfg_if.data;
        REG_LONG_MAX:       cfg_r.long_max       <= cfg_if.data;
        REG_EXTRA_LONG_MIN: cfg_r.extra_long_min <= cfg_if.data;
        REG_RELEASE_TICKS:  cfg_r.release_ticks  <= cfg_if.data[REL_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Classify the held request; state updates only when it advances.
  bcc_tracker u_tracker (
    .clk         (clk),
    .rst_n       (rst_n),
    .en          (advance),
    .action      (s1_action_r),
    .pin_level   (s1_pin_r),
    .cfg         (cfg_r),
    .event_res   (trk_event),
    .press_class (trk_class)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_if.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_event_r <= trk_event;
      out_class_r <= trk_class;
    end
  end

  assign out_if.valid       = out_valid_r;
  assign out_if.event_res   = out_event_r;
  assign out_if.press_class = out_class_r;

endmodule
